/* rtl/lpht_pkg.sv */
// package with shared types, constants and the key hash for the hash table unit
`timescale 1ns / 1ps
package lpht_pkg;

    localparam int TABLE_SLOTS_DEF = 1024;
    localparam int KEY_BYTES_DEF   = 4;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int OCC_W    = 11;
    localparam int STATUS_W = 2;

    localparam logic [7:0] HASH_SEED = 8'ha5;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_PUT    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // byte shift-xor hash, byte 0 least significant
    function automatic logic [31:0] key_hash(input logic [63:0] k, input int nbytes);
        logic [31:0] h;
        logic [31:0] d;
        int          s1;
        int          s2;
        h = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < nbytes) begin
                d  = {24'b0, k[8*i +: 8]};
                s1 = (5 * i) & 15;
                s2 = ((6 * i) & 15) + 8;
                h  = h + (({24'b0, HASH_SEED} ^ d) << s2) + (d << s1);
            end
        end
        return h;
    endfunction

endpackage

/* rtl/lpht_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/linear_probe_hash_table_unit.sv */
// top level: linear probing hash table sequencer around one slot ram
//
//  channel | ports                                          | dir
//  --------+------------------------------------------------+-----
//  s_      | s_valid s_ready s_opcode s_key s_value         | in
//  m_      | m_valid m_ready m_status m_existed             | out
//          | m_read_value m_occupancy                       |
//
// each probed slot passes S_P_RD (ram read), then S_P_CHK (check); hashing is S_HASH,
// followed by the reciprocal reduction in S_MOD when TABLE_SLOTS is not a power of two.
// accept (S_IDLE) and result hand-off (S_DONE) are states of their own for every item.
// remove re-hashes and re-probes every entry of the following run; a move adds two writes.
// clear all and reset both sweep every slot of the ram with s_ready low.
// one item at a time; a finished item waits in the output register while the next is taken.
`timescale 1ns / 1ps
module linear_probe_hash_table_unit #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lpht_pkg::opcode_t              s_opcode,
    input  logic [lpht_pkg::KEY_W-1:0]     s_key,
    input  logic [lpht_pkg::VALUE_W-1:0]   s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lpht_pkg::STATUS_W-1:0]  m_status,
    output logic                           m_existed,
    output logic [lpht_pkg::VALUE_W-1:0]   m_read_value,
    output logic [lpht_pkg::OCC_W-1:0]     m_occupancy
);
    import lpht_pkg::*;

    localparam int  AW   = $clog2(TABLE_SLOTS);
    localparam int  KW   = (8 * KEY_BYTES < KEY_W) ? 8 * KEY_BYTES : KEY_W;
    localparam int  VW   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int  CW   = $clog2(TABLE_SLOTS + 1);
    localparam int  EW   = 1 + KW + VW;
    localparam bit  POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);
    localparam int  QSH  = 32 + AW;
    localparam logic [32:0] RECIP = 33'((64'd1 << QSH) / 64'(TABLE_SLOTS));

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_HASH  = 11'b00000000010,
        S_MOD   = 11'b00000000100,
        S_P_RD  = 11'b00000001000,
        S_P_CHK = 11'b00000010000,
        S_R_NXT = 11'b00000100000,
        S_R_CHK = 11'b00001000000,
        S_MV1   = 11'b00010000000,
        S_MV2   = 11'b00100000000,
        S_CLR   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
        return (a == LAST_SLOT) ? '0 : a + 1'b1;
    endfunction

    state_t             state_reg, state_next;
    opcode_t            op_reg, op_next;
    logic [KW-1:0]      key_reg, key_next;
    logic [VW-1:0]      val_reg, val_next;
    logic [KW-1:0]      pkey_reg, pkey_next;
    logic               fix_reg, fix_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        quot_reg, quot_next;
    logic [1:0]         step_reg, step_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [CW-1:0]      m_reg, m_next;
    logic [KW-1:0]      ent_key_reg, ent_key_next;
    logic [VW-1:0]      ent_val_reg, ent_val_next;
    logic [CW-1:0]      count_reg, count_next;
    status_t            res_status_reg, res_status_next;
    logic               res_existed_reg, res_existed_next;
    logic [VW-1:0]      res_value_reg, res_value_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               clr_emit_reg, clr_emit_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic               out_existed_reg, out_existed_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [OCC_W-1:0]   out_occ_reg, out_occ_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [EW-1:0]      wr_data;
    logic [AW-1:0]      rd_addr;
    logic [EW-1:0]      rd_data;
    logic               rd_used;
    logic [KW-1:0]      rd_key;
    logic [VW-1:0]      rd_val;
    logic               key_match;
    logic               last_probe;
    logic [31:0]        hash_raw;
    logic [64:0]        recip_prod;
    logic [31:0]        back_prod;
    logic [31:0]        rem_fix;

    lpht_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_used    = rd_data[EW-1];
    assign rd_key     = rd_data[KW+VW-1:VW];
    assign rd_val     = rd_data[VW-1:0];
    assign key_match  = rd_key == pkey_reg;
    assign last_probe = n_reg == CW'(TABLE_SLOTS - 1);
    assign hash_raw   = key_hash(64'(pkey_reg), KEY_BYTES);
    assign recip_prod = {33'b0, rem_reg} * {32'b0, RECIP};
    assign back_prod  = quot_reg * 32'(TABLE_SLOTS);
    assign rem_fix    = (rem_reg >= 32'(TABLE_SLOTS)) ? rem_reg - 32'(TABLE_SLOTS) : rem_reg;

    assign s_ready      = state_reg == S_IDLE;
    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_existed    = out_existed_reg;
    assign m_read_value = out_value_reg;
    assign m_occupancy  = out_occ_reg;

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        pkey_next        = pkey_reg;
        fix_next         = fix_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        step_next        = step_reg;
        addr_next        = addr_reg;
        n_next           = n_reg;
        i_next           = i_reg;
        m_next           = m_reg;
        ent_key_next     = ent_key_reg;
        ent_val_next     = ent_val_reg;
        count_next       = count_reg;
        res_status_next  = res_status_reg;
        res_existed_next = res_existed_reg;
        res_value_next   = res_value_reg;
        clr_addr_next    = clr_addr_reg;
        clr_emit_next    = clr_emit_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_existed_next = out_existed_reg;
        out_value_next   = out_value_reg;
        out_occ_next     = out_occ_reg;
        wr_en            = 1'b0;
        wr_addr          = addr_reg;
        wr_data          = {1'b0, key_reg, val_reg};
        rd_addr          = addr_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next          = s_opcode;
                    key_next         = s_key[KW-1:0];
                    val_next         = s_value[VW-1:0];
                    pkey_next        = s_key[KW-1:0];
                    fix_next         = 1'b0;
                    res_status_next  = ST_DONE;
                    res_existed_next = 1'b0;
                    res_value_next   = '0;
                    if (s_opcode == OP_CLEAR) begin
                        count_next    = '0;
                        clr_addr_next = '0;
                        clr_emit_next = 1'b1;
                        state_next    = S_CLR;
                    end else begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                rem_next  = hash_raw;
                step_next = 2'd0;
                n_next    = '0;
                if (POW2) begin
                    addr_next  = hash_raw[AW-1:0];
                    state_next = S_P_RD;
                end else begin
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                // reciprocal quotient, back-multiply and subtract, one correcting subtract
                unique case (step_reg)
                    2'd0: begin
                        quot_next = 32'(recip_prod[64:QSH]);
                        step_next = 2'd1;
                    end
                    2'd1: begin
                        rem_next  = rem_reg - back_prod;
                        step_next = 2'd2;
                    end
                    default: begin
                        addr_next  = rem_fix[AW-1:0];
                        state_next = S_P_RD;
                    end
                endcase
            end
            S_P_RD: begin
                state_next = S_P_CHK;
            end
            S_P_CHK: begin
                if (rd_used && !key_match && !last_probe) begin
                    n_next     = n_reg + 1'b1;
                    addr_next  = slot_inc(addr_reg);
                    state_next = S_P_RD;
                end else if (fix_reg) begin
                    // an empty slot ahead of the entry means it moves there
                    state_next = !rd_used ? S_MV1 : S_R_NXT;
                end else begin
                    state_next = S_DONE;
                    unique case (op_reg)
                        OP_GET: begin
                            if (rd_used && key_match) begin
                                res_existed_next = 1'b1;
                                res_value_next   = rd_val;
                            end else begin
                                res_status_next = ST_NOT_FOUND;
                            end
                        end
                        OP_PUT: begin
                            if (rd_used && key_match) begin
                                wr_en            = 1'b1;
                                wr_data          = {1'b1, key_reg, val_reg};
                                res_existed_next = 1'b1;
                            end else if (!rd_used) begin
                                wr_en      = 1'b1;
                                wr_data    = {1'b1, key_reg, val_reg};
                                count_next = count_reg + 1'b1;
                            end else begin
                                res_status_next = ST_FULL;
                            end
                        end
                        OP_REMOVE: begin
                            if (rd_used && key_match) begin
                                wr_en            = 1'b1;
                                wr_data          = {1'b0, rd_key, rd_val};
                                res_existed_next = 1'b1;
                                if (count_reg != '0) begin
                                    count_next = count_reg - 1'b1;
                                end
                                i_next     = addr_reg;
                                m_next     = '0;
                                state_next = S_R_NXT;
                            end else begin
                                res_status_next = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            res_status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_R_NXT: begin
                if (m_reg == CW'(TABLE_SLOTS)) begin
                    state_next = S_DONE;
                end else begin
                    rd_addr    = slot_inc(i_reg);
                    i_next     = slot_inc(i_reg);
                    m_next     = m_reg + 1'b1;
                    state_next = S_R_CHK;
                end
            end
            S_R_CHK: begin
                if (!rd_used) begin
                    state_next = S_DONE;
                end else begin
                    ent_key_next = rd_key;
                    ent_val_next = rd_val;
                    pkey_next    = rd_key;
                    fix_next     = 1'b1;
                    state_next   = S_HASH;
                end
            end
            S_MV1: begin
                wr_en      = 1'b1;
                wr_addr    = addr_reg;
                wr_data    = {1'b1, ent_key_reg, ent_val_reg};
                state_next = S_MV2;
            end
            S_MV2: begin
                wr_en      = 1'b1;
                wr_addr    = i_reg;
                wr_data    = {1'b0, ent_key_reg, ent_val_reg};
                state_next = S_R_NXT;
            end
            S_CLR: begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = {1'b0, key_reg, val_reg};
                clr_addr_next = slot_inc(clr_addr_reg);
                if (clr_addr_reg == LAST_SLOT) begin
                    state_next = clr_emit_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_existed_next = res_existed_reg;
                    out_value_next   = VALUE_W'(res_value_reg);
                    out_occ_next     = OCC_W'(count_reg);
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            clr_emit_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_emit_reg  <= clr_emit_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        val_reg         <= val_next;
        pkey_reg        <= pkey_next;
        fix_reg         <= fix_next;
        rem_reg         <= rem_next;
        quot_reg        <= quot_next;
        step_reg        <= step_next;
        addr_reg        <= addr_next;
        n_reg           <= n_next;
        i_reg           <= i_next;
        m_reg           <= m_next;
        ent_key_reg     <= ent_key_next;
        ent_val_reg     <= ent_val_next;
        res_status_reg  <= res_status_next;
        res_existed_reg <= res_existed_next;
        res_value_reg   <= res_value_next;
        out_status_reg  <= out_status_next;
        out_existed_reg <= out_existed_next;
        out_value_reg   <= out_value_next;
        out_occ_reg     <= out_occ_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_SLOTS))
        else $error("stored count above slot count");
    a_move_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MV1 |=> state_reg == S_MV2)
        else $error("entry move not followed by vacating write");
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLR |-> !s_ready && wr_en)
        else $error("clearing sweep not writing or accepting items");
    a_probe_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_P_RD |=> state_reg == S_P_CHK)
        else $error("probe read not followed by check");
`endif

endmodule

/* tb/tb.sv */
// self-checking testbench for the linear probing hash table unit
`timescale 1ns / 1ps
module tb;
    import lpht_pkg::*;

    localparam int SLOTS = 1024;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [1:0]  status;
        logic        existed;
        logic [31:0] read_value;
        logic [10:0] occupancy;
    } result_t;

    typedef struct {
        opcode_t     op;
        logic [31:0] key;
        logic [31:0] value;
        bit          typed;
        result_t     res;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    opcode_t     s_opcode = OP_GET;
    logic [31:0] s_key = '0;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_existed;
    logic [31:0] m_read_value;
    logic [10:0] m_occupancy;

    linear_probe_hash_table_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_key(s_key), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_existed(m_existed), .m_read_value(m_read_value), .m_occupancy(m_occupancy)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow table
    bit          shadow_used [SLOTS];
    logic [31:0] shadow_key  [SLOTS];
    logic [31:0] shadow_val  [SLOTS];
    int          shadow_count;

    result_t     pending_results[$];
    int          errors;
    int          items_sent;
    int          results_seen;
    int          full_hits;
    int          cycles;
    int          burst_left;
    bit          long_hold;
    logic [31:0] cluster_keys[$];

    function automatic int home_of(logic [31:0] k);
        logic [31:0] h;
        logic [31:0] d;
        h = '0;
        for (int i = 0; i < 4; i++) begin
            d = {24'b0, k[8*i +: 8]};
            h = h + ((32'h000000a5 ^ d) << (((6 * i) % 16) + 8)) + (d << ((5 * i) % 16));
        end
        return int'(h % SLOTS);
    endfunction

    function automatic bit find_slot(logic [31:0] k, bit want_empty, output int slot);
        int i;
        i = home_of(k);
        slot = 0;
        for (int n = 0; n < SLOTS; n++) begin
            if (!shadow_used[i]) begin
                slot = i;
                return want_empty;
            end
            if (shadow_key[i] == k) begin
                slot = i;
                return 1'b1;
            end
            i = (i + 1) % SLOTS;
        end
        return 1'b0;
    endfunction

    function automatic result_t table_apply(opcode_t op, logic [31:0] k, logic [31:0] v);
        result_t r;
        int      s;
        int      d;
        int      i;
        r = '0;
        case (op)
            OP_GET: begin
                if (find_slot(k, 1'b0, s)) begin
                    r.existed = 1'b1;
                    r.read_value = shadow_val[s];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_PUT: begin
                if (!find_slot(k, 1'b1, s)) begin
                    r.status = ST_FULL;
                end else begin
                    if (shadow_used[s]) begin
                        r.existed = 1'b1;
                    end else begin
                        shadow_used[s] = 1'b1;
                        shadow_key[s] = k;
                        shadow_count++;
                    end
                    shadow_val[s] = v;
                end
            end
            OP_REMOVE: begin
                if (!find_slot(k, 1'b0, s)) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.existed = 1'b1;
                    shadow_used[s] = 1'b0;
                    if (shadow_count > 0) shadow_count--;
                    i = s;
                    // re-place the rest of the run
                    for (int n = 0; n < SLOTS; n++) begin
                        i = (i + 1) % SLOTS;
                        if (!shadow_used[i]) break;
                        if (find_slot(shadow_key[i], 1'b1, d) && d != i) begin
                            shadow_used[d] = 1'b1;
                            shadow_key[d] = shadow_key[i];
                            shadow_val[d] = shadow_val[i];
                            shadow_used[i] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                for (int n = 0; n < SLOTS; n++) shadow_used[n] = 1'b0;
                shadow_count = 0;
            end
        endcase
        r.occupancy = shadow_count[10:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
        errors++;
    endtask

    // offer one item and hold it until accepted; idle gaps fall between bursts
    task automatic send_item(opcode_t op, logic [31:0] k, logic [31:0] v, bit typed = 1'b0,
                             result_t want = '0);
        result_t r;
        int      gap;
        r = table_apply(op, k, v);
        pending_results.push_back(typed ? want : r);
        if (r.status == ST_FULL) full_hits++;
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_key    <= k;
        s_value  <= v;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(6);
            if (gap > 0) s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(11);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_results.size() == 0);
        @(posedge aclk);
    endtask

    task automatic mixed_items(int count);
        int          r;
        opcode_t     op;
        logic [31:0] k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            op = (r < 38) ? OP_PUT : (r < 66) ? OP_GET : (r < 98) ? OP_REMOVE : OP_CLEAR;
            if ($urandom_range(99) < 85)
                k = cluster_keys[$urandom_range(cluster_keys.size() - 1)];
            else
                k = $urandom;
            send_item(op, k, $urandom);
        end
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall pattern, plus one long hold-off on request
    initial begin
        int mode;
        int hold;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                hold++;
                m_ready <= 1'b0;
                if (hold >= 400) begin
                    long_hold = 1'b0;
                    hold = 0;
                end
            end else begin
                if ($urandom_range(63) == 0) mode = $urandom_range(2);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(1);
                    default: m_ready <= ($urandom_range(7) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("result %0d arrived with nothing expected", results_seen);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    report("status", 32'(m_status), 32'(want.status));
                if (m_existed !== want.existed)
                    report("existed", 32'(m_existed), 32'(want.existed));
                if (m_read_value !== want.read_value)
                    report("read_value", m_read_value, want.read_value);
                if (m_occupancy !== want.occupancy)
                    report("occupancy", 32'(m_occupancy), 32'(want.occupancy));
            end
        end
    end

    initial begin
        row_t        rows[$];
        logic [31:0] k;
        logic [31:0] slot_keys[SLOTS];
        bit          have[SLOTS];
        int          h;

        for (int n = 0; n < SLOTS; n++) shadow_used[n] = 1'b0;
        shadow_count = 0;
        burst_left = 0;

        // a dense cluster of keys homing near the wrap point
        while (cluster_keys.size() < 40) begin
            k = $urandom;
            if (((home_of(k) - 1016 + SLOTS) % SLOTS) < 16) cluster_keys.push_back(k);
        end
        // one key per home slot for the fill phase
        for (int n = 0; n < SLOTS; n++) have[n] = 1'b0;
        for (int t = 0; t < 200000; t++) begin
            k = $urandom;
            h = home_of(k);
            if (!have[h]) begin
                have[h] = 1'b1;
                slot_keys[h] = k;
            end
        end

        rows = '{
            '{OP_GET,    32'h0,        32'hffffffff, 1, '{ST_NOT_FOUND, 0, 0, 0}},
            '{OP_REMOVE, 32'h0,        32'h0,        1, '{ST_NOT_FOUND, 0, 0, 0}},
            '{OP_PUT,    32'hffffffff, 32'hffffffff, 1, '{ST_DONE, 0, 0, 1}},
            '{OP_GET,    32'hffffffff, 32'h0,        1, '{ST_DONE, 1, 32'hffffffff, 1}},
            '{OP_PUT,    32'hffffffff, 32'h0,        1, '{ST_DONE, 1, 0, 1}},
            '{OP_GET,    32'hffffffff, 32'h12345678, 1, '{ST_DONE, 1, 0, 1}},
            '{OP_PUT,    32'h0,        32'h0,        1, '{ST_DONE, 0, 0, 2}},
            '{OP_PUT,    32'h00000001, 32'ha5a5a5a5, 0, '0},
            '{OP_PUT,    32'h80000000, 32'h5a5a5a5a, 0, '0},
            '{OP_GET,    32'h00000001, 32'h0,        0, '0},
            '{OP_REMOVE, 32'hffffffff, 32'hffffffff, 1, '{ST_DONE, 1, 0, 3}},
            '{OP_GET,    32'hffffffff, 32'h0,        1, '{ST_NOT_FOUND, 0, 0, 3}},
            '{OP_REMOVE, 32'h0,        32'h0,        0, '0},
            '{OP_GET,    32'h80000000, 32'h0,        0, '0},
            '{OP_CLEAR,  32'hffffffff, 32'hffffffff, 1, '{ST_DONE, 0, 0, 0}},
            '{OP_GET,    32'h00000001, 32'h0,        1, '{ST_NOT_FOUND, 0, 0, 0}},
            '{OP_PUT,    32'h12345678, 32'h87654321, 0, '0},
            '{OP_CLEAR,  32'h0,        32'h0,        1, '{ST_DONE, 0, 0, 0}}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_item(rows[i].op, rows[i].key, rows[i].value,
                                    rows[i].typed, rows[i].res);
        // put colliding cluster keys with random values, then remove every second of the first sixteen
        for (int n = 0; n < 8; n++) send_item(OP_PUT, cluster_keys[n], $urandom);
        for (int n = 0; n < 8; n++) send_item(OP_REMOVE, cluster_keys[n * 2], $urandom);

        mixed_items(440);

        // fill every slot; the receiver holds off at the start of the fill so the block backs up
        drain();
        send_item(OP_CLEAR, $urandom, $urandom);
        long_hold = 1'b1;
        for (int n = 0; n < SLOTS; n++) send_item(OP_PUT, have[n] ? slot_keys[n] : $urandom,
                                                   $urandom);
        while (shadow_count < SLOTS) send_item(OP_PUT, $urandom, $urandom);
        for (int n = 0; n < 3; n++) begin
            do k = $urandom; while (find_slot(k, 1'b0, h));
            send_item(OP_PUT, k, $urandom);
            send_item(OP_GET, k, $urandom);
        end
        for (int n = 0; n < 4; n++) begin
            h = $urandom_range(SLOTS - 1);
            send_item(OP_PUT, shadow_key[h], $urandom);
            send_item(OP_GET, shadow_key[h], $urandom);
        end
        drain();
        send_item(OP_CLEAR, $urandom, $urandom);

        mixed_items(60);

        drain();
        repeat (60) @(posedge aclk);
        $display("sent %0d items, checked %0d results, %0d table-full puts",
                 items_sent, results_seen, full_hits);
        $display("covered empty, clustered, wrapped and full tables with clears between");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
